// ----- rtl/core/vrp_pkg.sv -----
// Package of the vertex rotate, project and viewport unit.
// Holds field widths, pixel limits, register indexes and configuration structs.
// Depends on nothing.
package vrp_pkg;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned SIZE_W    = 13;
  localparam int unsigned QUOT_BITS = 15;

  localparam logic signed [15:0] PIX_MAX = 16'sh7fff;
  localparam logic signed [15:0] PIX_MIN = 16'sh8000;

  localparam logic signed [15:0] RST_COS    = 16'sd16384;
  localparam logic signed [15:0] RST_SIN    = 16'sd0;
  localparam logic signed [15:0] RST_PROJ_X = 16'sd3072;
  localparam logic signed [15:0] RST_PROJ_Y = 16'sd4096;
  localparam logic [12:0]        RST_WIDTH  = 13'd640;
  localparam logic [12:0]        RST_HEIGHT = 13'd480;

  typedef enum logic [2:0] {
    REG_COS_Z,
    REG_SIN_Z,
    REG_COS_X,
    REG_SIN_X,
    REG_PROJ_X,
    REG_PROJ_Y,
    REG_WIDTH,
    REG_HEIGHT
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] cos_z;
    logic signed [15:0] sin_z;
    logic signed [15:0] cos_x;
    logic signed [15:0] sin_x;
  } rot_cfg_t;

  typedef struct packed {
    logic signed [15:0] proj_x;
    logic signed [15:0] proj_y;
    logic [12:0]        width;
    logic [12:0]        height;
  } proj_cfg_t;

endpackage

// ----- rtl/core/vrp_rotate.sv -----
// Two pipeline stages: rotation about Z, then rotation about X.
// Depends on vrp_pkg.
module vrp_rotate #(
  parameter int unsigned TRIG_FRAC_BITS = 14,
  parameter int unsigned RZ_W = 33 - TRIG_FRAC_BITS,
  parameter int unsigned R2_W = RZ_W + 17 - TRIG_FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [15:0]       x_i,
  input  logic signed [15:0]       y_i,
  input  logic signed [15:0]       z_i,
  input  vrp_pkg::rot_cfg_t        cfg_i,
  output logic                     valid_o,
  output logic signed [RZ_W-1:0]   rzx_o,
  output logic signed [R2_W-1:0]   ry_o,
  output logic signed [R2_W-1:0]   rz_o
);
  import vrp_pkg::*;

  localparam int unsigned S1 = 2 * COORD_W + 1;
  localparam int unsigned S2 = RZ_W + 17;

  logic signed [S1-1:0]   sum_a, sum_b;
  logic signed [S2-1:0]   sum_c, sum_d;
  logic                   v1_q, v2_q;
  logic signed [RZ_W-1:0] rzx1_q, rzy1_q, rzx2_q;
  logic signed [15:0]     z1_q;
  logic signed [R2_W-1:0] ry2_q, rz2_q;

  always_comb begin
    sum_a = S1'(x_i * cfg_i.cos_z) - S1'(y_i * cfg_i.sin_z);
    sum_b = S1'(x_i * cfg_i.sin_z) + S1'(y_i * cfg_i.cos_z);
    sum_c = S2'(rzy1_q * cfg_i.cos_x) - S2'(z1_q * cfg_i.sin_x);
    sum_d = S2'(rzy1_q * cfg_i.sin_x) + S2'(z1_q * cfg_i.cos_x);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rzx1_q <= RZ_W'(sum_a >>> TRIG_FRAC_BITS);
    rzy1_q <= RZ_W'(sum_b >>> TRIG_FRAC_BITS);
    z1_q   <= z_i;
    rzx2_q <= rzx1_q;
    ry2_q  <= R2_W'(sum_c >>> TRIG_FRAC_BITS);
    rz2_q  <= R2_W'(sum_d >>> TRIG_FRAC_BITS);
  end

  assign valid_o = v2_q;
  assign rzx_o   = rzx2_q;
  assign ry_o    = ry2_q;
  assign rz_o    = rz2_q;

endmodule

// ----- rtl/core/vrp_project.sv -----
// Two pipeline stages: projection scaling and depth offset, then the
// viewport numerators and the divisor. Depends on vrp_pkg.
module vrp_project #(
  parameter int unsigned COORD_FRAC_BITS = 12,
  parameter int unsigned RZ_W  = 19,
  parameter int unsigned R2_W  = 22,
  parameter int unsigned TOP_W = 53,
  parameter int unsigned DIV_W = 36
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [RZ_W-1:0]   rzx_i,
  input  logic signed [R2_W-1:0]   ry_i,
  input  logic signed [R2_W-1:0]   rz_i,
  input  vrp_pkg::proj_cfg_t       cfg_i,
  output logic                     valid_o,
  output logic signed [TOP_W-1:0]  top_x_o,
  output logic signed [TOP_W-1:0]  top_y_o,
  output logic [DIV_W-1:0]         den_o,
  output logic                     den_neg_o,
  output logic                     no_div_o
);
  import vrp_pkg::*;

  localparam int unsigned F    = COORD_FRAC_BITS;
  localparam int unsigned D_W  = ((R2_W > F + 3) ? R2_W : F + 3) + 1;
  localparam int unsigned N_W  = R2_W + 16;
  localparam int unsigned SA_W = (N_W > D_W + F) ? N_W : D_W + F;
  localparam int unsigned S_W  = ((SA_W > 2 * F + 2) ? SA_W : 2 * F + 2) + 1;

  logic                    v3_q, v4_q;
  logic signed [N_W-1:0]   nx_q, ny_q;
  logic signed [D_W-1:0]   d_q;
  logic signed [S_W-1:0]   dterm, sum_x, sum_y;
  logic [D_W-1:0]          abs_d;
  logic signed [TOP_W-1:0] top_x_q, top_y_q;
  logic [DIV_W-1:0]        den_d, den_q;
  logic                    neg_q, nodiv_q;

  always_comb begin
    abs_d = d_q[D_W-1] ? D_W'(-d_q) : D_W'(d_q);
    if (d_q != '0) begin
      dterm = S_W'(d_q) <<< F;
      den_d = DIV_W'(abs_d) << (F + 1);
    end else begin
      dterm = S_W'(1) <<< (2 * F);
      den_d = DIV_W'(1) << (2 * F + 1);
    end
    sum_x = S_W'(nx_q) + dterm;
    sum_y = S_W'(ny_q) + dterm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q    <= N_W'(rzx_i * cfg_i.proj_x);
    ny_q    <= N_W'(ry_i * cfg_i.proj_y);
    d_q     <= D_W'(rz_i) + (D_W'(3) <<< F);
    top_x_q <= TOP_W'(sum_x) * TOP_W'($signed({1'b0, cfg_i.width}));
    top_y_q <= TOP_W'(sum_y) * TOP_W'($signed({1'b0, cfg_i.height}));
    den_q   <= den_d;
    neg_q   <= d_q[D_W-1];
    nodiv_q <= (d_q == '0);
  end

  assign valid_o   = v4_q;
  assign top_x_o   = top_x_q;
  assign top_y_o   = top_y_q;
  assign den_o     = den_q;
  assign den_neg_o = neg_q;
  assign no_div_o  = nodiv_q;

endmodule

// ----- rtl/core/vrp_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, giving a
// truncated quotient saturated to 16 bits. Depends on vrp_pkg.
module vrp_divider #(
  parameter int unsigned TOP_W = 53,
  parameter int unsigned DIV_W = 36
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [TOP_W-1:0] num_i,
  input  logic [DIV_W-1:0]        den_i,
  input  logic                    den_neg_i,
  input  logic                    tag_i,
  output logic                    valid_o,
  output logic signed [15:0]      pix_o,
  output logic                    tag_o
);
  import vrp_pkg::*;

  localparam int unsigned CW = ((TOP_W > DIV_W + QUOT_BITS) ? TOP_W : DIV_W + QUOT_BITS) + 1;
  localparam int unsigned NS = QUOT_BITS + 1;

  logic                 val_q [NS];
  logic [TOP_W-1:0]     rem_q [NS];
  logic [DIV_W-1:0]     den_q [NS];
  logic [QUOT_BITS-1:0] quo_q [NS];
  logic                 neg_q [NS];
  logic                 sat_q [NS];
  logic                 tag_q [NS];

  logic [TOP_W-1:0]     mag;
  logic                 out_v_q, out_tag_q;
  logic signed [15:0]   pix_d, pix_q;

  assign mag = num_i[TOP_W-1] ? TOP_W'(-num_i) : TOP_W'(num_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q[0] <= 1'b0;
    end else begin
      val_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= mag;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    neg_q[0] <= num_i[TOP_W-1] ^ den_neg_i;
    sat_q[0] <= CW'(mag) >= (CW'(den_i) << QUOT_BITS);
    tag_q[0] <= tag_i;
  end

  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_step
    logic [CW-1:0] trial;
    logic          ge;

    always_comb begin
      trial = CW'(den_q[i]) << (QUOT_BITS - 1 - i);
      ge    = CW'(rem_q[i]) >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        val_q[i+1] <= 1'b0;
      end else begin
        val_q[i+1] <= val_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i+1] <= ge ? TOP_W'(CW'(rem_q[i]) - trial) : rem_q[i];
      den_q[i+1] <= den_q[i];
      quo_q[i+1] <= {quo_q[i][QUOT_BITS-2:0], ge};
      neg_q[i+1] <= neg_q[i];
      sat_q[i+1] <= sat_q[i];
      tag_q[i+1] <= tag_q[i];
    end
  end

  always_comb begin
    if (sat_q[NS-1]) begin
      pix_d = neg_q[NS-1] ? PIX_MIN : PIX_MAX;
    end else if (neg_q[NS-1]) begin
      pix_d = -$signed({1'b0, quo_q[NS-1]});
    end else begin
      pix_d = $signed({1'b0, quo_q[NS-1]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= val_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q     <= pix_d;
    out_tag_q <= tag_q[NS-1];
  end

  assign valid_o = out_v_q;
  assign pix_o   = pix_q;
  assign tag_o   = out_tag_q;

endmodule

// ----- rtl/core/vertex_rotate_project_viewport_unit.sv -----
// Top level of the vertex rotate, project and viewport unit.
// Depends on vrp_pkg, vrp_rotate, vrp_project and vrp_divider.
//
// The unit takes one vertex per cycle and returns each pixel position,
// marked by done_o for one cycle; busy_o is never raised and the receiver
// cannot stall the pipeline. The pipeline is two rotation stages, two
// projection stages, and the divider, which spends one stage on sign and
// range, one stage per quotient bit and one output stage.
module vertex_rotate_project_viewport_unit #(
  parameter int unsigned COORD_FRAC_BITS = 12,
  parameter int unsigned TRIG_FRAC_BITS  = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic signed [15:0] vertex_x_i,
  input  logic signed [15:0] vertex_y_i,
  input  logic signed [15:0] vertex_z_i,
  output logic               done_o,
  output logic signed [15:0] screen_x_o,
  output logic signed [15:0] screen_y_o,
  output logic               no_divide_o
);
  import vrp_pkg::*;

  localparam int unsigned F     = COORD_FRAC_BITS;
  localparam int unsigned RZ_W  = 33 - TRIG_FRAC_BITS;
  localparam int unsigned R2_W  = RZ_W + 17 - TRIG_FRAC_BITS;
  localparam int unsigned D_W   = ((R2_W > F + 3) ? R2_W : F + 3) + 1;
  localparam int unsigned N_W   = R2_W + 16;
  localparam int unsigned SA_W  = (N_W > D_W + F) ? N_W : D_W + F;
  localparam int unsigned S_W   = ((SA_W > 2 * F + 2) ? SA_W : 2 * F + 2) + 1;
  localparam int unsigned TOP_W = S_W + SIZE_W + 1;
  localparam int unsigned DIV_W = (D_W + F + 1 > 2 * F + 2) ? D_W + F + 1 : 2 * F + 2;
  localparam int unsigned LATENCY = 4 + QUOT_BITS + 2;

  rot_cfg_t  rot_cfg_q;
  proj_cfg_t proj_cfg_q;

  logic                    rot_v, proj_v, div_x_v, div_y_v;
  logic signed [RZ_W-1:0]  rzx;
  logic signed [R2_W-1:0]  ry, rz;
  logic signed [TOP_W-1:0] top_x, top_y;
  logic [DIV_W-1:0]        den;
  logic                    den_neg, no_div;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_cfg_q  <= '{cos_z: RST_COS, sin_z: RST_SIN, cos_x: RST_COS, sin_x: RST_SIN};
      proj_cfg_q <= '{proj_x: RST_PROJ_X, proj_y: RST_PROJ_Y,
                      width: RST_WIDTH, height: RST_HEIGHT};
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_COS_Z:  rot_cfg_q.cos_z   <= cfg_wdata_i;
        REG_SIN_Z:  rot_cfg_q.sin_z   <= cfg_wdata_i;
        REG_COS_X:  rot_cfg_q.cos_x   <= cfg_wdata_i;
        REG_SIN_X:  rot_cfg_q.sin_x   <= cfg_wdata_i;
        REG_PROJ_X: proj_cfg_q.proj_x <= cfg_wdata_i;
        REG_PROJ_Y: proj_cfg_q.proj_y <= cfg_wdata_i;
        REG_WIDTH:  proj_cfg_q.width  <= cfg_wdata_i[SIZE_W-1:0];
        REG_HEIGHT: proj_cfg_q.height <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  vrp_rotate #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
    .RZ_W(RZ_W),
    .R2_W(R2_W)
  ) u_rotate (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .valid_i(start_i && !busy_o),
    .x_i(vertex_x_i),
    .y_i(vertex_y_i),
    .z_i(vertex_z_i),
    .cfg_i(rot_cfg_q),
    .valid_o(rot_v),
    .rzx_o(rzx),
    .ry_o(ry),
    .rz_o(rz)
  );

  vrp_project #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .RZ_W(RZ_W),
    .R2_W(R2_W),
    .TOP_W(TOP_W),
    .DIV_W(DIV_W)
  ) u_project (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .valid_i(rot_v),
    .rzx_i(rzx),
    .ry_i(ry),
    .rz_i(rz),
    .cfg_i(proj_cfg_q),
    .valid_o(proj_v),
    .top_x_o(top_x),
    .top_y_o(top_y),
    .den_o(den),
    .den_neg_o(den_neg),
    .no_div_o(no_div)
  );

  vrp_divider #(
    .TOP_W(TOP_W),
    .DIV_W(DIV_W)
  ) u_div_x (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .valid_i(proj_v),
    .num_i(top_x),
    .den_i(den),
    .den_neg_i(den_neg),
    .tag_i(no_div),
    .valid_o(div_x_v),
    .pix_o(screen_x_o),
    .tag_o(no_divide_o)
  );

  vrp_divider #(
    .TOP_W(TOP_W),
    .DIV_W(DIV_W)
  ) u_div_y (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .valid_i(proj_v),
    .num_i(top_y),
    .den_i(den),
    .den_neg_i(den_neg),
    .tag_i(no_div),
    .valid_o(div_y_v),
    .pix_o(screen_y_o),
    .tag_o()
  );

  assign done_o = div_x_v;

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_x_v == div_y_v)
    else $error("x and y divider lanes out of step");

  a_request_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LATENCY done_o)
    else $error("request did not complete after the pipeline latency");

  a_done_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(start_i, LATENCY))
    else $error("result without a matching request");

endmodule
